@@ rtl/core/mtep_pkg.sv @@
// Shared types and constants of the MIDI track event parser.
// Holds the parser phase, the parser state record and the result record.
// No dependencies.
`timescale 1ns / 1ps

package mtep_pkg;

   localparam int DEF_MAX_VLQ_BYTES = 4;

   localparam int TICK_WIDTH   = 32;
   localparam int POS_WIDTH    = 32;
   localparam int LEN_WIDTH    = 28;
   localparam int DATA7_WIDTH  = 7;
   localparam int BYTE_WIDTH   = 8;
   localparam int RSP_DATA_WIDTH = 128;
   localparam int RSP_USER_WIDTH = 2;

   localparam logic [1:0] OUTCOME_EVENT     = 2'd0;
   localparam logic [1:0] OUTCOME_MALFORMED = 2'd1;
   localparam logic [1:0] OUTCOME_END       = 2'd2;

   localparam logic [7:0] STATUS_SYSEX       = 8'hF0;
   localparam logic [7:0] STATUS_QFRAME      = 8'hF1;
   localparam logic [7:0] STATUS_SONG_POS    = 8'hF2;
   localparam logic [7:0] STATUS_SONG_SEL    = 8'hF3;
   localparam logic [7:0] STATUS_ESCAPE      = 8'hF7;
   localparam logic [7:0] STATUS_META        = 8'hFF;
   localparam logic [7:0] STATUS_CHAN_MAX    = 8'hEF;
   localparam logic [7:0] META_END_OF_TRACK  = 8'h2F;
   localparam logic [3:0] CHAN_HI_PROGRAM    = 4'hC;
   localparam logic [3:0] CHAN_HI_PRESSURE   = 4'hD;

   typedef enum logic [3:0] {
      PH_DELTA     = 4'd0,
      PH_STATUS    = 4'd1,
      PH_META_TYPE = 4'd2,
      PH_META_LEN  = 4'd3,
      PH_SYSEX_LEN = 4'd4,
      PH_PAYLOAD   = 4'd5,
      PH_CHAN_D1   = 4'd6,
      PH_CHAN_D2   = 4'd7,
      PH_SKIP      = 4'd8
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [TICK_WIDTH-1:0]  tick_total;
      logic [BYTE_WIDTH-1:0]  running_status;
      logic [BYTE_WIDTH-1:0]  current_status;
      logic [LEN_WIDTH-1:0]   vlq_value;
      logic [LEN_WIDTH-1:0]   bytes_remaining;
      logic [POS_WIDTH-1:0]   byte_position;
      logic [BYTE_WIDTH-1:0]  held_meta_kind;
      logic [DATA7_WIDTH-1:0] held_first_data;
      logic [POS_WIDTH-1:0]   payload_start;
      logic                   halted;
   } parser_state_type;

   typedef struct packed {
      logic [1:0]             outcome;
      logic [TICK_WIDTH-1:0]  event_tick;
      logic [BYTE_WIDTH-1:0]  status_byte;
      logic [DATA7_WIDTH-1:0] first_data;
      logic [DATA7_WIDTH-1:0] second_data;
      logic [BYTE_WIDTH-1:0]  meta_kind;
      logic [POS_WIDTH-1:0]   payload_offset;
      logic [LEN_WIDTH-1:0]   payload_length;
   } result_type;

endpackage

@@ rtl/core/mtep_step.sv @@
// Combinational update of the parser for one track byte.
// Produces the next parser state and at most one result; uses mtep_pkg.
`timescale 1ns / 1ps

module mtep_step #(
   parameter int MAX_VLQ_BYTES = mtep_pkg::DEF_MAX_VLQ_BYTES,
   localparam int CntWidth = $clog2(MAX_VLQ_BYTES + 1)
) (
   input  mtep_pkg::parser_state_type          state_cur,
   input  logic [CntWidth-1:0]                 vlq_count_cur,
   input  logic [mtep_pkg::BYTE_WIDTH-1:0]     data_byte,
   input  logic                                last_byte,
   input  logic [mtep_pkg::POS_WIDTH-1:0]      track_start,
   output mtep_pkg::parser_state_type          state_nxt,
   output logic [CntWidth-1:0]                 vlq_count_nxt,
   output logic                                res_valid,
   output mtep_pkg::result_type                res
);

   logic [mtep_pkg::LEN_WIDTH-1:0] vlq_shift;
   logic [CntWidth-1:0]            cnt_inc;
   logic                           vlq_end;
   logic                           vlq_over;
   logic [mtep_pkg::POS_WIDTH-1:0] pos_inc;
   logic [mtep_pkg::LEN_WIDTH-1:0] rem_dec;
   logic [mtep_pkg::LEN_WIDTH-1:0] run_length;

   assign vlq_shift  = {state_cur.vlq_value[mtep_pkg::LEN_WIDTH-8:0], data_byte[6:0]};
   assign cnt_inc    = vlq_count_cur + CntWidth'(1);
   assign vlq_end    = !data_byte[7];
   assign vlq_over   = data_byte[7] && (cnt_inc >= CntWidth'(MAX_VLQ_BYTES));
   assign pos_inc    = state_cur.byte_position + mtep_pkg::POS_WIDTH'(1);
   assign rem_dec    = state_cur.bytes_remaining - mtep_pkg::LEN_WIDTH'(1);
   assign run_length = pos_inc[mtep_pkg::LEN_WIDTH-1:0]
                       - state_cur.payload_start[mtep_pkg::LEN_WIDTH-1:0];

   function automatic logic two_byte_msg(input logic [7:0] status);
      return (status[7:4] == mtep_pkg::CHAN_HI_PROGRAM) ||
             (status[7:4] == mtep_pkg::CHAN_HI_PRESSURE);
   endfunction

   function automatic logic ends_track(input mtep_pkg::parser_state_type s);
      return (s.current_status == mtep_pkg::STATUS_META) &&
             (s.held_meta_kind == mtep_pkg::META_END_OF_TRACK);
   endfunction

   // next state
   always_comb begin
      state_nxt     = state_cur;
      vlq_count_nxt = vlq_count_cur;
      if (!state_cur.halted) begin
         case (state_cur.phase)
            mtep_pkg::PH_DELTA: begin
               state_nxt.vlq_value = vlq_shift;
               vlq_count_nxt       = cnt_inc;
               if (vlq_over) begin
                  state_nxt.halted = 1'b1;
               end else if (vlq_end) begin
                  state_nxt.tick_total = state_cur.tick_total
                                         + mtep_pkg::TICK_WIDTH'(vlq_shift);
                  state_nxt.vlq_value  = '0;
                  vlq_count_nxt        = '0;
                  state_nxt.phase      = mtep_pkg::PH_STATUS;
               end
            end
            mtep_pkg::PH_STATUS: begin
               if (!data_byte[7]) begin
                  if (state_cur.running_status == '0) begin
                     state_nxt.halted = 1'b1;
                  end else begin
                     state_nxt.current_status  = state_cur.running_status;
                     state_nxt.held_first_data = data_byte[6:0];
                     state_nxt.phase = two_byte_msg(state_cur.running_status) ?
                                       mtep_pkg::PH_DELTA : mtep_pkg::PH_CHAN_D2;
                  end
               end else begin
                  state_nxt.current_status = data_byte;
                  if (data_byte <= mtep_pkg::STATUS_CHAN_MAX) begin
                     state_nxt.running_status = data_byte;
                     state_nxt.phase          = mtep_pkg::PH_CHAN_D1;
                  end else begin
                     state_nxt.running_status = '0;
                     if (data_byte == mtep_pkg::STATUS_META) begin
                        state_nxt.phase = mtep_pkg::PH_META_TYPE;
                     end else if (data_byte == mtep_pkg::STATUS_SYSEX ||
                                  data_byte == mtep_pkg::STATUS_ESCAPE) begin
                        state_nxt.phase = mtep_pkg::PH_SYSEX_LEN;
                     end else if (data_byte == mtep_pkg::STATUS_QFRAME ||
                                  data_byte == mtep_pkg::STATUS_SONG_SEL) begin
                        state_nxt.bytes_remaining = mtep_pkg::LEN_WIDTH'(1);
                        state_nxt.phase           = mtep_pkg::PH_SKIP;
                     end else if (data_byte == mtep_pkg::STATUS_SONG_POS) begin
                        state_nxt.bytes_remaining = mtep_pkg::LEN_WIDTH'(2);
                        state_nxt.phase           = mtep_pkg::PH_SKIP;
                     end else begin
                        state_nxt.phase = mtep_pkg::PH_DELTA;
                     end
                  end
               end
            end
            mtep_pkg::PH_META_TYPE: begin
               state_nxt.held_meta_kind = data_byte;
               state_nxt.phase          = mtep_pkg::PH_META_LEN;
            end
            mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
               state_nxt.vlq_value = vlq_shift;
               vlq_count_nxt       = cnt_inc;
               if (vlq_over) begin
                  state_nxt.halted = 1'b1;
               end else if (vlq_end) begin
                  state_nxt.vlq_value       = '0;
                  vlq_count_nxt             = '0;
                  state_nxt.payload_start   = pos_inc;
                  state_nxt.bytes_remaining = vlq_shift;
                  if (vlq_shift == '0) begin
                     state_nxt.phase = mtep_pkg::PH_DELTA;
                     if (ends_track(state_cur)) begin
                        state_nxt.halted = 1'b1;
                     end
                  end else begin
                     state_nxt.phase = mtep_pkg::PH_PAYLOAD;
                  end
               end
            end
            mtep_pkg::PH_PAYLOAD: begin
               state_nxt.bytes_remaining = rem_dec;
               if (rem_dec == '0) begin
                  state_nxt.phase = mtep_pkg::PH_DELTA;
                  if (ends_track(state_cur)) begin
                     state_nxt.halted = 1'b1;
                  end
               end
            end
            mtep_pkg::PH_CHAN_D1: begin
               state_nxt.held_first_data = data_byte[6:0];
               state_nxt.phase = two_byte_msg(state_cur.current_status) ?
                                 mtep_pkg::PH_DELTA : mtep_pkg::PH_CHAN_D2;
            end
            mtep_pkg::PH_CHAN_D2: begin
               state_nxt.phase = mtep_pkg::PH_DELTA;
            end
            mtep_pkg::PH_SKIP: begin
               state_nxt.bytes_remaining = rem_dec;
               if (rem_dec == '0) begin
                  state_nxt.phase = mtep_pkg::PH_DELTA;
               end
            end
            default: begin
               state_nxt.halted = 1'b1;
            end
         endcase
      end
      state_nxt.byte_position = pos_inc;
      if (last_byte) begin
         state_nxt       = '0;
         state_nxt.phase = mtep_pkg::PH_DELTA;
         vlq_count_nxt   = '0;
      end
   end

   // result
   always_comb begin
      mtep_pkg::result_type fin;
      logic                 fin_valid;
      logic [mtep_pkg::LEN_WIDTH-1:0] fin_len;
      logic [mtep_pkg::POS_WIDTH-1:0] fin_start;
      logic                 fail;

      fail      = 1'b0;
      res_valid = 1'b0;
      res       = '0;

      fin_len   = (state_cur.phase == mtep_pkg::PH_PAYLOAD) ? run_length : '0;
      fin_start = (state_cur.phase == mtep_pkg::PH_PAYLOAD) ?
                  state_cur.payload_start : pos_inc;
      fin                = '0;
      fin.event_tick     = state_cur.tick_total;
      fin.payload_offset = track_start + fin_start;
      fin.payload_length = fin_len;
      fin_valid          = 1'b0;
      if (state_cur.current_status == mtep_pkg::STATUS_META) begin
         fin_valid       = 1'b1;
         fin.status_byte = mtep_pkg::STATUS_META;
         fin.meta_kind   = state_cur.held_meta_kind;
         fin.outcome     = ends_track(state_cur) ? mtep_pkg::OUTCOME_END :
                           mtep_pkg::OUTCOME_EVENT;
      end else if (state_cur.current_status == mtep_pkg::STATUS_SYSEX) begin
         fin_valid       = 1'b1;
         fin.status_byte = mtep_pkg::STATUS_SYSEX;
         fin.outcome     = mtep_pkg::OUTCOME_EVENT;
      end

      if (!state_cur.halted) begin
         case (state_cur.phase)
            mtep_pkg::PH_DELTA: begin
               fail = vlq_over || last_byte;
            end
            mtep_pkg::PH_STATUS: begin
               if (!data_byte[7]) begin
                  if (state_cur.running_status == '0) begin
                     fail = 1'b1;
                  end else if (two_byte_msg(state_cur.running_status)) begin
                     res_valid       = 1'b1;
                     res.outcome     = mtep_pkg::OUTCOME_EVENT;
                     res.event_tick  = state_cur.tick_total;
                     res.status_byte = state_cur.running_status;
                     res.first_data  = data_byte[6:0];
                  end else begin
                     fail = last_byte;
                  end
               end else if (data_byte <= mtep_pkg::STATUS_CHAN_MAX ||
                            data_byte == mtep_pkg::STATUS_META ||
                            data_byte == mtep_pkg::STATUS_SYSEX ||
                            data_byte == mtep_pkg::STATUS_ESCAPE) begin
                  fail = last_byte;
               end
            end
            mtep_pkg::PH_META_TYPE: begin
               fail = last_byte;
            end
            mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
               if (vlq_over) begin
                  fail = 1'b1;
               end else if (vlq_end && vlq_shift == '0) begin
                  res_valid = fin_valid;
                  res       = fin;
               end else begin
                  fail = last_byte;
               end
            end
            mtep_pkg::PH_PAYLOAD: begin
               if (rem_dec == '0) begin
                  res_valid = fin_valid;
                  res       = fin;
               end else begin
                  fail = last_byte;
               end
            end
            mtep_pkg::PH_CHAN_D1: begin
               if (two_byte_msg(state_cur.current_status)) begin
                  res_valid       = 1'b1;
                  res.outcome     = mtep_pkg::OUTCOME_EVENT;
                  res.event_tick  = state_cur.tick_total;
                  res.status_byte = state_cur.current_status;
                  res.first_data  = data_byte[6:0];
               end else begin
                  fail = last_byte;
               end
            end
            mtep_pkg::PH_CHAN_D2: begin
               res_valid       = 1'b1;
               res.outcome     = mtep_pkg::OUTCOME_EVENT;
               res.event_tick  = state_cur.tick_total;
               res.status_byte = state_cur.current_status;
               res.first_data  = state_cur.held_first_data;
               res.second_data = data_byte[6:0];
            end
            mtep_pkg::PH_SKIP: begin
               fail = 1'b0;
            end
            default: begin
               fail = 1'b1;
            end
         endcase
      end

      if (fail) begin
         res_valid   = 1'b1;
         res         = '0;
         res.outcome = mtep_pkg::OUTCOME_MALFORMED;
      end
   end

endmodule

@@ rtl/core/midi_track_event_parser.sv @@
// Top level of the MIDI track event parser: input register, parser state,
// result register and stream handshakes; uses mtep_pkg and mtep_step.
`timescale 1ns / 1ps

// Takes one track byte per cycle while events are taken, and returns at most
// one event per byte. A byte accepted into the input register is parsed from
// there, and its event is loaded into the result register at the edge where
// the byte leaves the input register; the byte waits there while an untaken
// event fills the result register. The rate is set by the combinational
// parser state update between the input register and the state and result
// registers; the result register lets the next byte enter while an event
// waits to be taken. Write track_start only when no byte is in flight.

module midi_track_event_parser #(
   parameter int MAX_VLQ_BYTES = mtep_pkg::DEF_MAX_VLQ_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   // fields: data_byte[7:0]
   input  logic [7:0]                          req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // fields: event_tick[31:0], status_byte[39:32], first_data[46:40],
   // second_data[53:47], meta_kind[61:54], payload_offset[93:62],
   // payload_length[121:94], zero fill[127:122]
   output logic [mtep_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // fields: outcome[1:0]
   output logic [mtep_pkg::RSP_USER_WIDTH-1:0] rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [31:0]                         csr_wdata
);

   localparam int CntWidth = $clog2(MAX_VLQ_BYTES + 1);

   logic                       in_valid_ff, in_valid_in;
   logic [7:0]                 in_byte_ff;
   logic                       in_last_ff;
   mtep_pkg::parser_state_type state_ff, state_in;
   logic [CntWidth-1:0]        vlq_count_ff, vlq_count_in;
   logic [31:0]                track_start_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   mtep_pkg::result_type       rsp_data_ff;
   logic                       step_res_valid;
   mtep_pkg::result_type       step_res;
   logic                       advance;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   mtep_step #(
      .MAX_VLQ_BYTES(MAX_VLQ_BYTES)
   ) u_step (
      .state_cur    (state_ff),
      .vlq_count_cur(vlq_count_ff),
      .data_byte    (in_byte_ff),
      .last_byte    (in_last_ff),
      .track_start  (track_start_ff),
      .state_nxt    (state_in),
      .vlq_count_nxt(vlq_count_in),
      .res_valid    (step_res_valid),
      .res          (step_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = step_res_valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= '0;
         vlq_count_ff   <= '0;
         track_start_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff     <= state_in;
            vlq_count_ff <= vlq_count_in;
         end
         if (csr_we) begin
            track_start_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && step_res_valid) begin
         rsp_data_ff <= step_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.outcome;
   assign rsp_tdata  = {6'b0,
                        rsp_data_ff.payload_length,
                        rsp_data_ff.payload_offset,
                        rsp_data_ff.meta_kind,
                        rsp_data_ff.second_data,
                        rsp_data_ff.first_data,
                        rsp_data_ff.status_byte,
                        rsp_data_ff.event_tick};

   a_last_clears : assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff.phase == mtep_pkg::PH_DELTA &&
                                !state_ff.halted && state_ff.byte_position == '0)
      else $error("final byte did not return the parser to its start state");

   a_halted_silent : assert property (@(posedge clock) disable iff (reset)
      advance && state_ff.halted |=> !rsp_valid_ff)
      else $error("halted parser produced a result");

   a_malformed_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.outcome == mtep_pkg::OUTCOME_MALFORMED |->
         rsp_data_ff.event_tick == '0 && rsp_data_ff.status_byte == '0 &&
         rsp_data_ff.payload_length == '0)
      else $error("malformed result carries non-zero fields");

endmodule

@@ test/midi_track_event_parser_tb.sv @@
// Testbench for midi_track_event_parser: streams track bytes, predicts each event,
// malformed or end-of-track result in a model of its own and checks every field.
// Depends on mtep_pkg and the midi_track_event_parser RTL.
`timescale 1ns / 1ps

module midi_track_event_parser_tb;

   localparam int MAX_NUMBER_BYTES = mtep_pkg::DEF_MAX_VLQ_BYTES;
   localparam int SETTLE_CYCLES    = 8;
   localparam int HOLD_CYCLES      = 120;
   localparam int TIMEOUT_NS       = 3_000_000;

   typedef enum {NUM_OVERLONG, NUM_MORE, NUM_DONE} number_step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [mtep_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [mtep_pkg::RSP_USER_WIDTH-1:0] rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   // parser model state
   mtep_pkg::phase_type parse_phase;
   logic [31:0] tick_sum;
   logic [7:0]  run_status;
   logic [7:0]  cur_status;
   logic [27:0] num_value;
   int          num_count;
   logic [27:0] skip_left;
   logic [31:0] byte_pos;
   logic [7:0]  meta_kind_held;
   logic [6:0]  first_held;
   logic [31:0] payload_pos;
   logic        parse_halted;
   logic [31:0] track_start_reg = '0;

   mtep_pkg::result_type expected_events[$];
   logic [7:0]  track_bytes[$];
   int          error_count = 0;
   int          bytes_sent = 0;
   int          send_idle_pct = 0;
   int          rsp_idle_pct = 0;
   int          hold_count = 0;
   int          hold_taken = 0;
   int          hold_left = 0;

   midi_track_event_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void clear_parser();
      parse_phase    = mtep_pkg::PH_DELTA;
      tick_sum       = '0;
      run_status     = '0;
      cur_status     = '0;
      num_value      = '0;
      num_count      = 0;
      skip_left      = '0;
      byte_pos       = '0;
      meta_kind_held = '0;
      first_held     = '0;
      payload_pos    = '0;
      parse_halted   = 1'b0;
   endfunction

   function automatic mtep_pkg::result_type event_fields(input logic [1:0] oc,
         input logic [7:0] st, input logic [6:0] d1, input logic [6:0] d2,
         input logic [7:0] kind, input logic [31:0] off, input logic [27:0] len);
      mtep_pkg::result_type r;
      r.outcome        = oc;
      r.event_tick     = (oc == mtep_pkg::OUTCOME_MALFORMED) ? 32'd0 : tick_sum;
      r.status_byte    = st;
      r.first_data     = d1;
      r.second_data    = d2;
      r.meta_kind      = kind;
      r.payload_offset = off;
      r.payload_length = len;
      return r;
   endfunction

   function automatic bit report_malformed(output mtep_pkg::result_type r);
      r = event_fields(mtep_pkg::OUTCOME_MALFORMED, '0, '0, '0, '0, '0, '0);
      parse_halted = 1'b1;
      return 1'b1;
   endfunction

   function automatic bit end_check(input logic last, output mtep_pkg::result_type r);
      r = '0;
      if (last) return report_malformed(r);
      return 1'b0;
   endfunction

   function automatic number_step_type take_number(input logic [7:0] b);
      num_value = {num_value[20:0], b[6:0]};
      num_count++;
      if (!b[7]) return NUM_DONE;
      return (num_count >= MAX_NUMBER_BYTES) ? NUM_OVERLONG : NUM_MORE;
   endfunction

   function automatic bit finish_payload(input logic [27:0] len,
         output mtep_pkg::result_type r);
      logic [31:0] off;
      off = track_start_reg + payload_pos;
      r = '0;
      parse_phase = mtep_pkg::PH_DELTA;
      if (cur_status == mtep_pkg::STATUS_META) begin
         if (meta_kind_held == mtep_pkg::META_END_OF_TRACK) begin
            r = event_fields(mtep_pkg::OUTCOME_END, mtep_pkg::STATUS_META, '0, '0,
                             meta_kind_held, off, len);
            parse_halted = 1'b1;
         end else begin
            r = event_fields(mtep_pkg::OUTCOME_EVENT, mtep_pkg::STATUS_META, '0, '0,
                             meta_kind_held, off, len);
         end
         return 1'b1;
      end
      if (cur_status == mtep_pkg::STATUS_SYSEX) begin
         r = event_fields(mtep_pkg::OUTCOME_EVENT, mtep_pkg::STATUS_SYSEX, '0, '0, '0,
                          off, len);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit chan_first(input logic [7:0] b, input logic last,
         output mtep_pkg::result_type r);
      first_held = b[6:0];
      if (cur_status[7:4] == mtep_pkg::CHAN_HI_PROGRAM ||
          cur_status[7:4] == mtep_pkg::CHAN_HI_PRESSURE) begin
         parse_phase = mtep_pkg::PH_DELTA;
         r = event_fields(mtep_pkg::OUTCOME_EVENT, cur_status, first_held, '0, '0, '0, '0);
         return 1'b1;
      end
      parse_phase = mtep_pkg::PH_CHAN_D2;
      return end_check(last, r);
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, input logic last,
         output mtep_pkg::result_type r);
      number_step_type step;
      logic [27:0] len;
      r = '0;
      if (parse_halted) return 1'b0;
      case (parse_phase)
         mtep_pkg::PH_DELTA: begin
            step = take_number(b);
            if (step == NUM_OVERLONG) return report_malformed(r);
            if (step == NUM_MORE) return end_check(last, r);
            tick_sum    = tick_sum + 32'(num_value);
            num_value   = '0;
            num_count   = 0;
            parse_phase = mtep_pkg::PH_STATUS;
            return end_check(last, r);
         end
         mtep_pkg::PH_STATUS: begin
            if (!b[7]) begin
               if (run_status == '0) return report_malformed(r);
               cur_status = run_status;
               return chan_first(b, last, r);
            end
            cur_status = b;
            if (b <= mtep_pkg::STATUS_CHAN_MAX) begin
               run_status  = b;
               parse_phase = mtep_pkg::PH_CHAN_D1;
               return end_check(last, r);
            end
            run_status = '0;
            if (b == mtep_pkg::STATUS_META) begin
               parse_phase = mtep_pkg::PH_META_TYPE;
               return end_check(last, r);
            end
            if (b == mtep_pkg::STATUS_SYSEX || b == mtep_pkg::STATUS_ESCAPE) begin
               parse_phase = mtep_pkg::PH_SYSEX_LEN;
               return end_check(last, r);
            end
            if (b == mtep_pkg::STATUS_QFRAME || b == mtep_pkg::STATUS_SONG_SEL) begin
               skip_left   = 28'd1;
               parse_phase = mtep_pkg::PH_SKIP;
            end else if (b == mtep_pkg::STATUS_SONG_POS) begin
               skip_left   = 28'd2;
               parse_phase = mtep_pkg::PH_SKIP;
            end else begin
               parse_phase = mtep_pkg::PH_DELTA;
            end
            return 1'b0;
         end
         mtep_pkg::PH_META_TYPE: begin
            meta_kind_held = b;
            parse_phase    = mtep_pkg::PH_META_LEN;
            return end_check(last, r);
         end
         mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
            step = take_number(b);
            if (step == NUM_OVERLONG) return report_malformed(r);
            if (step == NUM_MORE) return end_check(last, r);
            len         = num_value;
            num_value   = '0;
            num_count   = 0;
            payload_pos = byte_pos + 32'd1;
            skip_left   = len;
            if (len == '0) return finish_payload('0, r);
            parse_phase = mtep_pkg::PH_PAYLOAD;
            return end_check(last, r);
         end
         mtep_pkg::PH_PAYLOAD: begin
            skip_left = skip_left - 28'd1;
            if (skip_left == '0) begin
               len = 28'(byte_pos + 32'd1 - payload_pos);
               return finish_payload(len, r);
            end
            return end_check(last, r);
         end
         mtep_pkg::PH_CHAN_D1: return chan_first(b, last, r);
         mtep_pkg::PH_CHAN_D2: begin
            parse_phase = mtep_pkg::PH_DELTA;
            r = event_fields(mtep_pkg::OUTCOME_EVENT, cur_status, first_held, b[6:0],
                             '0, '0, '0);
            return 1'b1;
         end
         mtep_pkg::PH_SKIP: begin
            skip_left = skip_left - 28'd1;
            if (skip_left == '0) parse_phase = mtep_pkg::PH_DELTA;
            return 1'b0;
         end
         default: return report_malformed(r);
      endcase
      return 1'b0;
   endfunction

   task automatic predict_byte(input logic [7:0] b, input logic last);
      mtep_pkg::result_type r;
      if (parse_byte(b, last, r)) expected_events.push_back(r);
      byte_pos = byte_pos + 32'd1;
      if (last) clear_parser();
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= b;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_byte(b, last);
      bytes_sent++;
   endtask

   // first byte in the top bits
   task automatic send_bytes(input logic [63:0] seq, input int count, input logic close);
      for (int i = 0; i < count; i++)
         send_byte(seq[8*(count-1-i) +: 8], close && (i == count - 1));
   endtask

   task automatic send_track();
      foreach (track_bytes[i]) send_byte(track_bytes[i], i == track_bytes.size() - 1);
   endtask

   task automatic add_number(input logic [27:0] v);
      int n;
      n = 1;
      while (n < MAX_NUMBER_BYTES && (v >> (7 * n)) != 0) n++;
      for (int i = n - 1; i >= 0; i--)
         track_bytes.push_back({i != 0, 7'(v >> (7 * i))});
   endtask

   function automatic logic [7:0] data_value();
      if ($urandom_range(9) == 0) return 8'($urandom_range(255));
      return 8'($urandom_range(127));
   endfunction

   task automatic add_payload(input int n);
      add_number(28'(n));
      repeat (n) track_bytes.push_back(8'($urandom_range(255)));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_track_start(input logic [31:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      track_start_reg = v;
   endtask

   task automatic send_random_track(input int target);
      logic       running;
      logic       stop;
      logic [7:0] st;
      int         pick;
      int         n;
      track_bytes.delete();
      running = 1'b0;
      stop    = 1'b0;
      st      = '0;
      while (track_bytes.size() < target && !stop) begin
         if ($urandom_range(9) == 0) add_number(28'($urandom));
         else add_number(28'($urandom_range(127)));
         pick = $urandom_range(99);
         if (pick < 50) begin
            if (!running || $urandom_range(2) == 0) begin
               st = 8'($urandom_range(8'hEF, 8'h80));
               track_bytes.push_back(st);
               running = 1'b1;
            end
            track_bytes.push_back(data_value());
            if (st[7:4] != mtep_pkg::CHAN_HI_PROGRAM &&
                st[7:4] != mtep_pkg::CHAN_HI_PRESSURE)
               track_bytes.push_back(data_value());
         end else if (pick < 65) begin
            track_bytes.push_back(mtep_pkg::STATUS_META);
            track_bytes.push_back(8'($urandom_range(255)));
            add_payload($urandom_range(6));
            running = 1'b0;
         end else if (pick < 75) begin
            track_bytes.push_back($urandom_range(1) ? mtep_pkg::STATUS_SYSEX :
                                                      mtep_pkg::STATUS_ESCAPE);
            add_payload($urandom_range(6));
            running = 1'b0;
         end else if (pick < 83) begin
            st = 8'($urandom_range(8'hFE, 8'hF1));
            if (st == mtep_pkg::STATUS_ESCAPE) st = mtep_pkg::STATUS_SONG_POS;
            track_bytes.push_back(st);
            n = (st == mtep_pkg::STATUS_QFRAME || st == mtep_pkg::STATUS_SONG_SEL) ? 1 :
                (st == mtep_pkg::STATUS_SONG_POS) ? 2 : 0;
            repeat (n) track_bytes.push_back(data_value());
            running = 1'b0;
         end else if (pick < 87) begin
            track_bytes.push_back(mtep_pkg::STATUS_META);
            track_bytes.push_back(mtep_pkg::META_END_OF_TRACK);
            add_payload($urandom_range(2));
            repeat ($urandom_range(3)) track_bytes.push_back(8'($urandom_range(255)));
            stop = 1'b1;
         end else if (pick < 91) begin
            // overlong length, or a huge length cut short by the final byte
            track_bytes.push_back($urandom_range(1) ? mtep_pkg::STATUS_META :
                                                      mtep_pkg::STATUS_SYSEX);
            if (track_bytes[track_bytes.size() - 1] == mtep_pkg::STATUS_META)
               track_bytes.push_back(8'($urandom_range(255)));
            if ($urandom_range(1)) begin
               repeat (MAX_NUMBER_BYTES) track_bytes.push_back(8'h80 | 8'($urandom_range(127)));
            end else begin
               add_number(28'($urandom_range(28'h0FFFFFFF, 28'h00200000)));
               repeat ($urandom_range(3)) track_bytes.push_back(8'($urandom_range(255)));
            end
            stop = 1'b1;
         end else begin
            repeat ($urandom_range(4, 1)) track_bytes.push_back(8'($urandom_range(255)));
            running = 1'b0;
         end
      end
      if ($urandom_range(9) == 0) begin
         n = $urandom_range(track_bytes.size(), 1);
         while (track_bytes.size() > n) void'(track_bytes.pop_back());
      end
      send_track();
   endtask

   task automatic test_channel_events();
      send_bytes(32'h00903C7F, 4, 1'b0);
      send_bytes(32'h8100C5FF, 4, 1'b0);
      send_bytes(16'h7F3C, 2, 1'b0);
      send_bytes(32'h00FF2F00, 4, 1'b0);
      send_bytes(8'h55, 1, 1'b1);
   endtask

   task automatic test_malformed_input();
      send_bytes(16'h003C, 2, 1'b0);
      send_bytes(8'h55, 1, 1'b1);
      send_bytes(40'h8080808000, 5, 1'b1);
      send_bytes(24'h00903C, 3, 1'b1);
   endtask

   task automatic test_random_tracks(input int count);
      int stop_at;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) send_random_track($urandom_range(48, 4));
   endtask

   task automatic test_tick_wrap();
      track_bytes.delete();
      repeat (20) begin
         add_number(28'($urandom_range(28'h0FFFFFFF, 28'h0E000000)));
         track_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
         track_bytes.push_back(8'($urandom_range(127)));
         track_bytes.push_back(8'($urandom_range(127)));
      end
      track_bytes.push_back(8'h00);
      track_bytes.push_back(mtep_pkg::STATUS_META);
      track_bytes.push_back(mtep_pkg::META_END_OF_TRACK);
      track_bytes.push_back(8'h00);
      send_track();
   endtask

   task automatic test_output_backpressure();
      hold_count++;
      send_random_track(64);
   endtask

   always @(posedge clock) begin
      if (hold_taken != hold_count) begin
         hold_taken <= hold_count;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
         input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      mtep_pkg::result_type got;
      mtep_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.outcome        = rsp_tuser[1:0];
         got.event_tick     = rsp_tdata[31:0];
         got.status_byte    = rsp_tdata[39:32];
         got.first_data     = rsp_tdata[46:40];
         got.second_data    = rsp_tdata[53:47];
         got.meta_kind      = rsp_tdata[61:54];
         got.payload_offset = rsp_tdata[93:62];
         got.payload_length = rsp_tdata[121:94];
         if (expected_events.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, got);
            error_count++;
         end else begin
            want = expected_events.pop_front();
            check_field("outcome", 32'(want.outcome), 32'(got.outcome));
            check_field("event_tick", want.event_tick, got.event_tick);
            check_field("status_byte", 32'(want.status_byte), 32'(got.status_byte));
            check_field("first_data", 32'(want.first_data), 32'(got.first_data));
            check_field("second_data", 32'(want.second_data), 32'(got.second_data));
            check_field("meta_kind", 32'(want.meta_kind), 32'(got.meta_kind));
            check_field("payload_offset", want.payload_offset, got.payload_offset);
            check_field("payload_length", 32'(want.payload_length),
                        32'(got.payload_length));
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      clear_parser();
      send_idle_pct = 11;
      rsp_idle_pct  = 52;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_channel_events();
      test_malformed_input();
      set_track_start(32'hFFFF_FFFF);
      test_random_tracks(220);

      send_idle_pct = 52;
      rsp_idle_pct  = 11;
      set_track_start($urandom);
      test_random_tracks(200);
      test_tick_wrap();

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      set_track_start(32'h0000_0000);
      test_output_backpressure();
      test_random_tracks(120);

      drain();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
